// ===== rtl/bsi_pkg.sv =====
// Package for the bounded sorted insert block.
// Holds the sizing constants, the key type and the cell control struct.
// No dependencies.
package bsi_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CFG_W     = 5;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	typedef struct packed {
		logic valid;
		logic left_le;
		logic load;
	} cell_ctl_t;

endpackage

// ===== rtl/bsi_cell.sv =====
// One slot of the sorted list: holds one key and compares it with the broadcast key.
// Depends on bsi_pkg for the key type and the control struct.
module bsi_cell (
	input  logic              clk,
	input  bsi_pkg::key_t     key,
	input  bsi_pkg::key_t     left_entry,
	input  bsi_pkg::cell_ctl_t ctl,
	output bsi_pkg::key_t     entry,
	output logic              le,
	output logic              ins
);
	import bsi_pkg::*;

	key_t entry_q;

	assign le    = ctl.valid && !(entry_q > key);
	assign ins   = ctl.left_le && !le;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load && !le) begin
			entry_q <= ins ? key : left_entry;
		end
	end

endmodule

// ===== rtl/bounded_sorted_insert.sv =====
// Top level of the bounded sorted insert block.
// Depends on bsi_pkg and instantiates a row of bsi_cell slots.
//
// The block keeps the smallest keys seen, in ascending order, up to the configured
// capacity. A transaction is taken at any edge where start is high; busy stays low, so
// one key per clock cycle is taken. Every slot compares its key with the new key in the
// same cycle and shifts toward the end of the list, so the result appears on the result
// ports in the cycle after the key, marked by done for exactly one cycle. The receiver
// cannot stall, so done must be sampled whenever it is high. The capacity register is
// written through cfg_valid and cfg_ready; a value of zero acts as one and a value above
// the slot count acts as the slot count. After reset the list is empty.
module bounded_sorted_insert (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [31:0]         new_key,
	output logic                       done,
	output logic                       accepted,
	output logic [3:0]                 insert_position,
	output logic [4:0]                 entry_count_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bsi_pkg::CFG_W-1:0]  cfg_data
);
	import bsi_pkg::*;

	logic [CFG_W-1:0] cap_cfg_q;
	cnt_t             cnt_q;
	cnt_t             cap_eff;
	cnt_t             cnt_eff;
	cnt_t             cnt_next;
	logic             full;
	logic             reject;
	logic             take;
	key_t             key;
	idx_t             pos;
	key_t             entry_vec [CAPACITY];
	logic [CAPACITY-1:0] le_vec;
	logic [CAPACITY-1:0] ins_vec;

	logic       done_q;
	logic       accepted_q;
	idx_t       pos_q;
	cnt_t       count_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;
	assign key       = KEY_WIDTH'(new_key);

	always_comb begin
		if (cap_cfg_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_cfg_q) > 32'(CAPACITY)) begin
			cap_eff = CNT_W'(CAPACITY);
		end else begin
			cap_eff = CNT_W'(cap_cfg_q);
		end
		cnt_eff  = (cnt_q > cap_eff) ? cap_eff : cnt_q;
		full     = (cnt_eff == cap_eff);
		reject   = full && (entry_vec[IDX_W'(cap_eff - CNT_W'(1))] < key);
		cnt_next = full ? cnt_eff : cnt_eff + CNT_W'(1);
		pos      = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (ins_vec[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
		if (full && le_vec[IDX_W'(cap_eff - CNT_W'(1))]) begin
			pos = IDX_W'(cap_eff - CNT_W'(1));
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int LEFT = (g == 0) ? 0 : g - 1;
		cell_ctl_t ctl;
		key_t      left_entry;

		always_comb begin
			ctl.valid   = (CNT_W'(g) < cnt_eff);
			ctl.load    = take && !reject;
			if (g == 0) begin
				ctl.left_le = 1'b1;
				left_entry  = key;
			end else begin
				ctl.left_le = le_vec[LEFT];
				left_entry  = entry_vec[LEFT];
			end
		end

		bsi_cell u_cell (
			.clk        (clk),
			.key        (key),
			.left_entry (left_entry),
			.ctl        (ctl),
			.entry      (entry_vec[g]),
			.le         (le_vec[g]),
			.ins        (ins_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= CFG_W'(16);
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_cfg_q <= cfg_data;
			end
			if (take) begin
				cnt_q <= reject ? cnt_eff : cnt_next;
			end
			done_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			accepted_q <= !reject;
			pos_q      <= reject ? '0 : pos;
			count_q    <= reject ? cnt_eff : cnt_next;
		end
	end

	assign done            = done_q;
	assign accepted        = accepted_q;
	assign insert_position = 4'(pos_q);
	assign entry_count_out = 5'(count_q);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take))
		else $error("Result strobe without a preceding transaction.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(CAPACITY))
		else $error("Entry count exceeds the number of slots.");

	a_insert_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ins_vec))
		else $error("More than one slot claims the insert position.");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (entry_count_out != 5'd0 &&
			5'(insert_position) < entry_count_out))
		else $error("Accepted key lies outside the reported list length.");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(take && reject) |=> (done && !accepted && insert_position == 4'd0))
		else $error("Rejected key reported incorrectly.");

endmodule

// ===== sim/tb_bounded_sorted_insert.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_sorted_insert: directed and random keys under several capacities.
// Keeps its own sorted list to predict every result and checks it when done is high.
// Depends on bsi_pkg and the bounded_sorted_insert RTL.
module tb_bounded_sorted_insert;
	import bsi_pkg::*;

	typedef struct packed {
		logic       accepted;
		logic [3:0] position;
		logic [4:0] count;
	} insert_result_t;

	localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
	localparam key_t KEY_MIN = 32'sh8000_0000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] new_key;
	logic               done;
	logic               accepted;
	logic [3:0]         insert_position;
	logic [4:0]         entry_count_out;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;

	key_t             sorted_list [CAPACITY];
	int               list_count;
	logic [CFG_W-1:0] capacity_reg;
	insert_result_t   pending_insertions [$];
	int               fail_count;
	int               sender_idle_pct;
	bit               start_q;

	bounded_sorted_insert u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.new_key         (new_key),
		.done            (done),
		.accepted        (accepted),
		.insert_position (insert_position),
		.entry_count_out (entry_count_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic insert_result_t compute_insertion(key_t key);
		insert_result_t r;
		int             cap;
		int             p;
		bit             full;
		cap = capacity_reg;
		if (cap == 0) cap = 1;
		if (cap > CAPACITY) cap = CAPACITY;
		if (list_count > cap) list_count = cap;
		full = (list_count == cap);
		if (full && sorted_list[cap-1] < key) begin
			r.accepted = 1'b0;
			r.position = '0;
			r.count    = 5'(list_count);
			return r;
		end
		p = full ? cap - 1 : list_count;
		while (p > 0 && sorted_list[p-1] > key) begin
			sorted_list[p] = sorted_list[p-1];
			p--;
		end
		sorted_list[p] = key;
		if (!full) list_count++;
		r.accepted = 1'b1;
		r.position = 4'(p);
		r.count    = 5'(list_count);
		return r;
	endfunction

	function automatic key_t random_key();
		key_t k;
		case ($urandom_range(3))
			0: k = $urandom;
			1: k = key_t'($urandom_range(20)) - 10;
			2: k = $urandom_range(1) ? KEY_MIN + key_t'($urandom_range(7))
			                         : KEY_MAX - key_t'($urandom_range(7));
			default: begin
				if (list_count > 0)
					k = sorted_list[list_count-1] - key_t'($urandom_range(3));
				else
					k = $urandom;
			end
		endcase
		return k;
	endfunction

	task automatic send_key(key_t key);
		start   <= 1'b1;
		start_q  = 1'b1;
		new_key <= key;
		do @(posedge clk); while (busy !== 1'b0);
		pending_insertions.push_back(compute_insertion(key));
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			start   <= 1'b0;
			start_q  = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	task automatic wait_idle();
		if (start_q) begin
			start   <= 1'b0;
			start_q  = 1'b0;
		end
		while (pending_insertions.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_capacity(logic [CFG_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		capacity_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_capacity();
		sender_idle_pct = 0;
		send_key(KEY_MAX);
		send_key(KEY_MIN);
		send_key(0);
		send_key(-1);
		send_key(5);
		send_key(5);
	endtask

	// The list is cut to three entries, then a larger key is rejected, a key equal to
	// the last entry replaces it, and a duplicate of the smallest key goes after it.
	task automatic test_capacity_cut();
		set_capacity(CFG_W'(3));
		send_key(7);
		send_key(0);
		send_key(KEY_MIN);
	endtask

	task automatic test_capacity_zero();
		set_capacity(CFG_W'(0));
		send_key(KEY_MAX);
		send_key(KEY_MIN);
	endtask

	task automatic test_capacity_above();
		set_capacity(CFG_W'(31));
		send_key(100);
		send_key(-100);
		send_key(0);
		send_key(KEY_MAX);
	endtask

	task automatic test_pause_drain();
		set_capacity(CFG_W'(8));
		sender_idle_pct = 25;
		repeat (20) send_key(random_key());
		wait_idle();
		repeat (20) send_key(random_key());
	endtask

	task automatic test_random_traffic();
		int caps [8] = '{16, 1, 2, 31, 5, 0, 17, 16};
		int idles [3] = '{0, 60, 25};
		int ph;
		for (ph = 0; ph < 10; ph++) begin
			set_capacity(CFG_W'(ph < 8 ? caps[ph] : $urandom_range(31)));
			sender_idle_pct = idles[ph % 3];
			repeat (150) send_key(random_key());
		end
	endtask

	always @(posedge clk) begin : check_results
		insert_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_insertions.size() == 0) begin
				$error("unexpected result: no transaction pending");
				fail_count++;
			end else begin
				want = pending_insertions.pop_front();
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, actual %0d", want.accepted, accepted);
					fail_count++;
				end
				if (insert_position !== want.position) begin
					$error("insert_position: expected %0d, actual %0d",
					       want.position, insert_position);
					fail_count++;
				end
				if (entry_count_out !== want.count) begin
					$error("entry_count_out: expected %0d, actual %0d",
					       want.count, entry_count_out);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		new_key         = '0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		start_q         = 1'b0;
		fail_count      = 0;
		sender_idle_pct = 0;
		list_count      = 0;
		capacity_reg    = 5'd16;
		foreach (sorted_list[i]) sorted_list[i] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_capacity();
		test_capacity_cut();
		test_capacity_zero();
		test_capacity_above();
		test_pause_drain();
		test_random_traffic();

		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
